@@ hw/rtl/pps_pkg.sv @@
// Shared constants and types for the prime sieve block.
`timescale 1ns / 1ps

package pps_pkg;

    // Width of the candidate and value fields on the channels.
    localparam int FIELD_W = 16;

    // Default configuration of the sieve.
    localparam int NUM_STAGES_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Status of the shared remainder unit, seen by the sequencer.
    typedef struct packed {
        logic done;
        logic divisible;
    } t_rem_status;

endpackage

@@ hw/rtl/pps_stream_if.sv @@
// Handshake interfaces for the candidate and result channels of the sieve.
`timescale 1ns / 1ps

interface pps_cand_if;
    logic                        valid;
    logic                        ready;
    logic [pps_pkg::FIELD_W-1:0] candidate;
    logic                        last;

    modport source (output valid, output candidate, output last, input ready);
    modport sink   (input valid, input candidate, input last, output ready);
endinterface

interface pps_res_if;
    logic                        valid;
    logic                        ready;
    logic [pps_pkg::FIELD_W-1:0] value;
    logic                        is_prime;
    logic                        overflow;
    logic                        end_of_stream;

    modport source (output valid, output value, output is_prime, output overflow,
                    output end_of_stream, input ready);
    modport sink   (input valid, input value, input is_prime, input overflow,
                    input end_of_stream, output ready);
endinterface

@@ hw/rtl/pipelined_prime_sieve_top.sv @@
// Top level of the prime sieve: sequencer, prime store and remainder unit.
`timescale 1ns / 1ps

// The sieve takes one candidate at a time and answers each with one result.
// The stored primes live in a RAM and are tested in order by a single
// bit-serial remainder unit. For each filled stage the sequencer reads the
// prime from the RAM (S_READ), starts the remainder unit with it (S_LOAD)
// and waits for it to finish (S_DIV); a candidate is tested until it is
// dropped or has passed all filled stages, and is then placed or flagged as
// overflow. Candidates below two, and any candidate while no prime is
// stored, go straight to S_FINISH. The input is ready only between
// candidates; a finished result waits in the output register while the next
// candidate is taken. After a result with end_of_stream set the fill count
// returns to zero, which empties all stages at once.
module pipelined_prime_sieve_top #(
    parameter int NUM_STAGES  = pps_pkg::NUM_STAGES_DEF,
    parameter int VALUE_WIDTH = pps_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pps_cand_if.sink    i_in,
    pps_res_if.source   o_out
);
    localparam int IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_idx;
    logic [VALUE_WIDTH-1:0] r_cand;
    logic                   r_last;
    logic                   r_dropped;
    logic                   r_below2;

    logic                        r_out_valid;
    logic [pps_pkg::FIELD_W-1:0] r_out_value;
    logic                        r_out_prime;
    logic                        r_out_ovf;
    logic                        r_out_eos;

    logic [VALUE_WIDTH-1:0] w_cand;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_place;
    logic                   w_we;
    logic [VALUE_WIDTH-1:0] w_rdata;
    pps_pkg::t_rem_status   w_rem;

    assign w_cand     = VALUE_WIDTH'(i_in.candidate);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_full     = (r_count == CNT_W'(NUM_STAGES));
    assign w_place    = !r_below2 && !r_dropped && !w_full;
    assign w_we       = (r_state == S_FINISH) && w_out_free && w_place;

    pps_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_STAGES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_cand),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    pps_rem #(
        .W (VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_cand),
        .i_divisor  (w_rdata),
        .o_status   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_dropped   <= 1'b0;
            r_below2    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_FINISH the output register is either refilled or still held.
            if (o_out.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cand    <= w_cand;
                        r_last    <= i_in.last;
                        r_idx     <= '0;
                        r_dropped <= 1'b0;
                        r_below2  <= (w_cand < VALUE_WIDTH'(2));
                        // Nothing to test: go straight to the result.
                        if (w_cand < VALUE_WIDTH'(2) || r_count == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rem.done) begin
                        if (w_rem.divisible) begin
                            r_dropped <= 1'b1;
                            r_state   <= S_FINISH;
                        end else if (r_idx + CNT_W'(1) == r_count) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= pps_pkg::FIELD_W'(r_cand);
                        r_out_prime <= w_place;
                        r_out_ovf   <= !r_below2 && !r_dropped && w_full;
                        r_out_eos   <= r_last;
                        if (r_last) begin
                            r_count <= '0;
                        end else if (w_place) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_out_value;
    assign o_out.is_prime      = r_out_prime;
    assign o_out.overflow      = r_out_ovf;
    assign o_out.end_of_stream = r_out_eos;

endmodule

@@ hw/rtl/pps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pps_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module pps_rem #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output pps_pkg::t_rem_status o_status
);
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvd;
    logic [W-1:0]     r_dvs;
    logic [W:0]       w_shift;
    logic [W-1:0]     n_rem;

    // Shift the next dividend bit into the partial remainder and subtract
    // the divisor when it fits.
    always_comb begin
        w_shift = {r_rem, r_dvd[W-1]};
        if (w_shift >= {1'b0, r_dvs}) begin
            n_rem = W'(w_shift - {1'b0, r_dvs});
        end else begin
            n_rem = w_shift[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done      = r_done;
    assign o_status.divisible = (r_rem == '0);

endmodule

@@ hw/rtl/pps_checker.sv @@
// Port-level checks for the prime sieve, bound to its top level.
`timescale 1ns / 1ps

module pps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pps_pkg::FIELD_W-1:0] i_out_value,
    input logic                        i_out_is_prime,
    input logic                        i_out_overflow
);

    // A result is never both a new prime and an overflow.
    a_prime_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_is_prime && i_out_overflow))
        else $error("result flags both prime and overflow");

    // After a candidate transaction the sieve is busy and drops its input ready.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a candidate transaction");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_value) && $stable(i_out_is_prime) && $stable(i_out_overflow)))
        else $error("result payload changed while stalled");

endmodule

bind pipelined_prime_sieve_top pps_checker u_pps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.value),
    .i_out_is_prime (o_out.is_prime),
    .i_out_overflow (o_out.overflow)
);

@@ tb/tb.sv @@
// Self-checking testbench for the pipelined prime sieve with a driver, a monitor and a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int SIEVE_DEPTH    = pps_pkg::NUM_STAGES_DEF;
    localparam int VALUE_W        = pps_pkg::VALUE_WIDTH_DEF;
    localparam int FIELD_W        = pps_pkg::FIELD_W;
    localparam int DRAIN_CYCLES   = 1300;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS    = 382;
    localparam int NUM_PHASES     = 4;
    localparam longint TIMEOUT_NS = 40_000_000;

    typedef struct {
        logic [FIELD_W-1:0] candidate;
        logic               last;
    } t_cand_item;

    typedef struct {
        logic [FIELD_W-1:0] value;
        logic               is_prime;
        logic               overflow;
        logic               end_of_stream;
    } t_sieve_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pps_cand_if cand_bus ();
    pps_res_if  res_bus ();

    pipelined_prime_sieve_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cand_bus),
        .o_out   (res_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cand_item    cand_queue[$];
    t_sieve_result predicted_results[$];
    int            err_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            pressure_go = 1'b0;
    bit            rx_hold = 1'b0;

    // Predictor state: the primes held by the filter stages and how many are filled.
    logic [VALUE_W-1:0] sieve_primes [SIEVE_DEPTH];
    int                 sieve_fill = 0;

    initial begin
        for (int k = 0; k < SIEVE_DEPTH; k++) sieve_primes[k] = '0;
    end

    function automatic t_sieve_result sieve_classify(input logic [FIELD_W-1:0] cand_in,
                                                     input logic last_in);
        t_sieve_result      r;
        logic [VALUE_W-1:0] cand;
        bit                 divided;
        int                 k;
        cand            = cand_in[VALUE_W-1:0];
        divided         = 1'b0;
        r.value         = FIELD_W'(cand);
        r.is_prime      = 1'b0;
        r.overflow      = 1'b0;
        r.end_of_stream = last_in;
        if (cand >= 2) begin
            for (k = 0; k < sieve_fill && !divided; k++) begin
                if (sieve_primes[k] != 0 && (cand % sieve_primes[k]) == 0) divided = 1'b1;
            end
            if (!divided) begin
                if (sieve_fill < SIEVE_DEPTH) begin
                    sieve_primes[sieve_fill] = cand;
                    sieve_fill++;
                    r.is_prime = 1'b1;
                end else begin
                    r.overflow = 1'b1;
                end
            end
        end
        if (last_in) begin
            for (k = 0; k < SIEVE_DEPTH; k++) sieve_primes[k] = '0;
            sieve_fill = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Driver: offers queued candidates and records the prediction for each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_bus.valid <= 1'b0;
        end else if (!cand_bus.valid || cand_bus.ready) begin
            if (cand_bus.valid) begin
                predicted_results.push_back(sieve_classify(cand_bus.candidate, cand_bus.last));
            end
            if (cand_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cand_bus.valid     <= 1'b1;
                cand_bus.candidate <= cand_queue[0].candidate;
                cand_bus.last      <= cand_queue[0].last;
                void'(cand_queue.pop_front());
            end else begin
                cand_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_sieve_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result, value", int'(res_bus.value), -1);
                end else begin
                    want = predicted_results.pop_front();
                    if (res_bus.value !== want.value)
                        report_mismatch("value", int'(res_bus.value), int'(want.value));
                    if (res_bus.is_prime !== want.is_prime)
                        report_mismatch("is_prime", int'(res_bus.is_prime),
                                        int'(want.is_prime));
                    if (res_bus.overflow !== want.overflow)
                        report_mismatch("overflow", int'(res_bus.overflow),
                                        int'(want.overflow));
                    if (res_bus.end_of_stream !== want.end_of_stream)
                        report_mismatch("end_of_stream", int'(res_bus.end_of_stream),
                                        int'(want.end_of_stream));
                end
            end
            res_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the result register fills and the input stalls.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic add_item(input int cand, input bit last_flag);
        t_cand_item it;
        it.candidate = FIELD_W'(cand);
        it.last      = last_flag;
        cand_queue.push_back(it);
    endtask

    // Mostly ascending streams from 2 with some stray values; a few streams are long
    // enough to fill every stage and overflow.
    task automatic add_random_streams(input int total, input bit start_long);
        int left;
        int len;
        int v;
        int cand;
        bit want_long;
        left      = total;
        want_long = start_long;
        while (left > 0) begin
            if (want_long) begin
                len       = 360;
                want_long = 1'b0;
            end else if ($urandom_range(0, 99) < 10) begin
                len = $urandom_range(300, 400);
            end else begin
                len = $urandom_range(1, 60);
            end
            if (len > left) len = left;
            for (v = 0; v < len; v++) begin
                cand = v + 2;
                if ($urandom_range(0, 99) < 8) cand = $urandom_range(0, 65535);
                add_item(cand, v == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        cand_bus.valid     = 1'b0;
        cand_bus.candidate = '0;
        cand_bus.last      = 1'b0;
        res_bus.ready      = 1'b0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: small primes and composites, a repeated prime, values below two,
        // extreme values, then an empty sieve after end of stream.
        add_item(2, 0);      add_item(3, 0);      add_item(4, 0);
        add_item(5, 0);      add_item(6, 0);      add_item(7, 0);
        add_item(9, 0);      add_item(2, 0);      add_item(0, 0);
        add_item(1, 0);      add_item(65535, 0);  add_item(32768, 0);
        add_item(65521, 0);  add_item(49, 0);     add_item(25, 0);
        add_item(11, 1);     add_item(0, 0);      add_item(1, 0);
        add_item(4, 0);      add_item(8, 0);      add_item(65521, 0);
        add_item(2, 1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(posedge i_clk);
            case (ph)
                0: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  <= 49;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 49;
                end
                default: begin
                    send_idle_pct  <= 31;
                    recv_stall_pct <= 31;
                end
            endcase
            add_random_streams(PHASE_ITEMS, ph == 0);
            if (ph == 0) pressure_go = 1'b1;
            while (cand_queue.size() != 0) @(posedge i_clk);
        end

        while (cand_queue.size() != 0 || cand_bus.valid) @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT at %0t", $realtime);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
